// ===== src/cti_pkg.sv =====
package cti_pkg;

    localparam int W_VOLT  = 9;
    localparam int W_VAL   = 24;
    localparam int W_DX    = W_VOLT + 1;       // signed voltage difference
    localparam int W_PROD  = W_VAL + W_DX;     // value times voltage difference
    localparam int W_NUM   = W_PROD + 1;       // difference of two products
    localparam int W_MAG   = W_NUM - 1;        // magnitude of the numerator
    localparam int W_ADDR  = 3;
    localparam int W_TDATA_IN = 16;

    localparam int MAX_POINTS  = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [W_VAL-1:0] VAL_MAX = 24'sh7FFFFF;

    // register indexes of the configuration port
    localparam logic [W_ADDR-1:0] REG_VOLT_A  = 3'd0;
    localparam logic [W_ADDR-1:0] REG_VALUE_A = 3'd3;
    localparam logic [W_ADDR-1:0] REG_FLOOR   = 3'd6;

    localparam logic [W_VOLT-1:0] RST_VOLT [MAX_POINTS] = '{9'd65, 9'd240, 9'd0};
    localparam logic signed [W_VAL-1:0] RST_VALUE [MAX_POINTS] =
        '{24'sd0, 24'sd20316, 24'sd0};
    localparam logic signed [W_VAL-1:0] RST_FLOOR = 24'sd0;

    typedef enum logic [1:0] {
        KIND_INTERP,
        KIND_EXACT,
        KIND_ERROR
    } t_kind;

    // one classified transaction, handed from front to back
    typedef struct packed {
        t_kind                    kind;
        logic signed [W_VAL-1:0]  w1;   // also carries the exact-match value
        logic signed [W_VAL-1:0]  w2;
        logic signed [W_DX-1:0]   dx1;  // x - v1
        logic signed [W_DX-1:0]   dx2;  // x - v2
        logic signed [W_DX-1:0]   den;  // v2 - v1
    } t_job;

endpackage

// ===== src/cti_front.sv =====
module cti_front #(
    parameter int POINTS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [cti_pkg::W_VOLT-1:0]        i_x,
    input  logic [cti_pkg::W_VOLT-1:0]        i_volt  [POINTS],
    input  logic signed [cti_pkg::W_VAL-1:0]  i_value [POINTS],
    output logic                              o_push,
    output cti_pkg::t_job                     o_job,
    input  logic                              i_full
);
    import cti_pkg::*;

    localparam int CW = $clog2(POINTS + 1);
    localparam int IW = $clog2(POINTS);

    logic               r_valid;
    logic               n_valid;
    t_job               r_job;
    t_job               n_job;
    logic               accept;

    logic [CW-1:0]      cnt;
    logic [W_VOLT-1:0]  last_volt;
    logic [IW-1:0]      n1;
    logic [IW-1:0]      n2;
    logic               found;
    logic               got;
    logic               few;
    logic [W_VOLT-1:0]  v1;
    logic [W_VOLT-1:0]  v2;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_job   = r_job;

    // segment selection over the leading valid points
    always_comb begin
        cnt       = '0;
        last_volt = '0;
        n1        = '0;
        n2        = '0;
        found     = 1'b0;
        got       = 1'b0;
        for (int i = 0; i < POINTS; i++) begin
            if (i_volt[i] != '0) begin
                cnt = cnt + CW'(1);
            end
        end
        for (int i = 0; i < POINTS; i++) begin
            if (CW'(i) == cnt - CW'(1)) begin
                last_volt = i_volt[i];
            end
        end
        few = cnt < CW'(2);
        if (few) begin
            n1 = '0;
        end else if (i_x < i_volt[0]) begin
            n1 = IW'(1);
            n2 = '0;
        end else if (i_x > last_volt) begin
            n1 = IW'(cnt - CW'(1));
            n2 = IW'(cnt - CW'(2));
        end else begin
            for (int i = POINTS - 1; i >= 0; i--) begin
                if (CW'(i) < cnt && !found && !got) begin
                    if (i_volt[i] == i_x) begin
                        found = 1'b1;
                        n1    = IW'(i);
                    end else if (i_volt[i] < i_x) begin
                        got = 1'b1;
                        n1  = IW'(i);
                    end
                end
            end
            got = 1'b0;
            for (int i = 0; i < POINTS; i++) begin
                if (CW'(i) < cnt && !found && !got) begin
                    if (i_volt[i] == i_x) begin
                        found = 1'b1;
                        n1    = IW'(i);
                    end else if (i_volt[i] > i_x) begin
                        got = 1'b1;
                        n2  = IW'(i);
                    end
                end
            end
        end

        v1        = i_volt[n1];
        v2        = i_volt[n2];
        n_job.w1  = i_value[n1];
        n_job.w2  = i_value[n2];
        n_job.dx1 = signed'({1'b0, i_x}) - signed'({1'b0, v1});
        n_job.dx2 = signed'({1'b0, i_x}) - signed'({1'b0, v2});
        n_job.den = signed'({1'b0, v2}) - signed'({1'b0, v1});

        if (few) begin
            n_job.kind = KIND_ERROR;
        end else if (found) begin
            n_job.kind = KIND_EXACT;
        end else if (n_job.den == '0) begin
            n_job.kind = KIND_ERROR;
        end else begin
            n_job.kind = KIND_INTERP;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== src/cti_queue.sv =====
module cti_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cti_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output cti_pkg::t_job o_job
);
    import cti_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [NW-1:0]   r_count;
    logic [NW-1:0]   n_count;

    assign o_full  = r_count == NW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== src/cti_back.sv =====
module cti_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    output logic                              o_pop,
    input  cti_pkg::t_job                     i_job,
    input  logic signed [cti_pkg::W_VAL-1:0]  i_floor,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [cti_pkg::W_VAL-1:0]  o_value,
    output logic                              o_clamped,
    output logic                              o_error
);
    import cti_pkg::*;

    localparam int DIV_STEPS = W_VAL;
    localparam int W_DMAG    = W_VOLT;

    typedef struct packed {
        t_kind                     kind;
        logic signed [W_VAL-1:0]   pv;
        logic signed [W_PROD-1:0]  p1;
        logic signed [W_PROD-1:0]  p2;
        logic signed [W_DX-1:0]    den;
    } t_mul;

    typedef struct packed {
        t_kind                     kind;
        logic signed [W_VAL-1:0]   pv;
        logic signed [W_NUM-1:0]   num;
        logic signed [W_DX-1:0]    den;
    } t_sub;

    typedef struct packed {
        t_kind                     kind;
        logic signed [W_VAL-1:0]   pv;
        logic [W_MAG-1:0]          num_mag;
        logic [W_DMAG-1:0]         den_mag;
        logic                      neg;
    } t_mag;

    typedef struct packed {
        t_kind                     kind;
        logic signed [W_VAL-1:0]   pv;
        logic                      neg;
        logic                      big;   // quotient magnitude of 2^24 or more
        logic [W_DMAG-1:0]         d;
        logic [W_DMAG-1:0]         rem;
        logic [W_VAL-1:0]          qlo;   // dividend bits in, quotient bits out
    } t_div;

    function automatic t_div div_step(input t_div s);
        t_div               r;
        logic [W_DMAG:0]    t;
        logic [W_DMAG:0]    diff;
        logic               ge;
        r    = s;
        t    = {s.rem, s.qlo[W_VAL-1]};
        diff = t - {1'b0, s.d};
        ge   = t >= {1'b0, s.d};
        r.rem = ge ? diff[W_DMAG-1:0] : t[W_DMAG-1:0];
        r.qlo = {s.qlo[W_VAL-2:0], ge};
        return r;
    endfunction

    logic                       en;
    logic                       r_v_mul;
    logic                       r_v_sub;
    logic                       r_v_mag;
    logic [DIV_STEPS:0]         r_v_div;
    logic                       r_v_out;
    t_mul                       r_mul;
    t_sub                       r_sub;
    t_mag                       r_mag;
    t_div                       r_div [DIV_STEPS+1];
    t_div                       n_div0;
    t_div                       last;
    logic signed [W_VAL:0]      sres;
    logic signed [W_VAL-1:0]    n_value;
    logic                       n_clamped;
    logic                       n_error;
    logic signed [W_VAL-1:0]    r_value;
    logic                       r_clamped;
    logic                       r_error;

    // whole pipeline holds while a finished result waits
    assign en      = !r_v_out || i_ready;
    assign o_pop   = en && i_q_valid;
    assign o_valid = r_v_out;
    assign o_value = r_value;
    assign o_clamped = r_clamped;
    assign o_error   = r_error;

    always_comb begin
        n_div0.kind = r_mag.kind;
        n_div0.pv   = r_mag.pv;
        n_div0.neg  = r_mag.neg;
        n_div0.big  = r_mag.num_mag >= {1'b0, r_mag.den_mag, {W_VAL{1'b0}}};
        n_div0.d    = r_mag.den_mag;
        n_div0.rem  = r_mag.num_mag[W_MAG-2 -: W_DMAG];
        n_div0.qlo  = r_mag.num_mag[W_VAL-1:0];
    end

    always_comb begin
        last      = r_div[DIV_STEPS];
        sres      = last.neg ? -signed'({1'b0, last.qlo}) : signed'({1'b0, last.qlo});
        n_value   = i_floor;
        n_clamped = 1'b0;
        n_error   = 1'b0;
        case (last.kind)
            KIND_EXACT: begin
                n_value = last.pv;
            end
            KIND_INTERP: begin
                if (last.big) begin
                    if (last.neg) begin
                        n_clamped = 1'b1;
                    end else begin
                        n_value = VAL_MAX;
                    end
                end else if (sres > (W_VAL+1)'(VAL_MAX)) begin
                    n_value = VAL_MAX;
                end else if (sres < (W_VAL+1)'(i_floor)) begin
                    n_clamped = 1'b1;
                end else begin
                    n_value = sres[W_VAL-1:0];
                end
            end
            default: begin
                n_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
            r_v_sub <= 1'b0;
            r_v_mag <= 1'b0;
            r_v_div <= '0;
            r_v_out <= 1'b0;
        end else if (en) begin
            r_v_mul <= i_q_valid;
            r_v_sub <= r_v_mul;
            r_v_mag <= r_v_sub;
            r_v_div <= {r_v_div[DIV_STEPS-1:0], r_v_mag};
            r_v_out <= r_v_div[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mul.kind <= i_job.kind;
            r_mul.pv   <= i_job.w1;
            r_mul.p2   <= i_job.w2 * i_job.dx1;
            r_mul.p1   <= i_job.w1 * i_job.dx2;
            r_mul.den  <= i_job.den;

            r_sub.kind <= r_mul.kind;
            r_sub.pv   <= r_mul.pv;
            r_sub.num  <= W_NUM'(r_mul.p2) - W_NUM'(r_mul.p1);
            r_sub.den  <= r_mul.den;

            r_mag.kind    <= r_sub.kind;
            r_mag.pv      <= r_sub.pv;
            r_mag.num_mag <= r_sub.num[W_NUM-1] ? W_MAG'(-r_sub.num) : W_MAG'(r_sub.num);
            r_mag.den_mag <= r_sub.den[W_DX-1] ? W_DMAG'(-r_sub.den) : W_DMAG'(r_sub.den);
            r_mag.neg     <= r_sub.num[W_NUM-1] ^ r_sub.den[W_DX-1];

            r_div[0] <= n_div0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_div[k] <= div_step(r_div[k-1]);
            end

            r_value   <= n_value;
            r_clamped <= n_clamped;
            r_error   <= n_error;
        end
    end

endmodule

// ===== src/calibration_table_interpolator.sv =====
// Calibration table interpolator.
// Input stream (s_axis): one detector voltage per transaction, centivolts.
// Output stream (m_axis): one calibrated value per input, in input order,
// with a clamp flag and a table error flag on tuser.
// Configuration: i_cfg_we/i_cfg_addr/i_cfg_wdata write the table points and
// the floor; write only while no transaction is in flight.
// Stages from input acceptance to m_axis_tvalid, in order: front register,
// queue, two multiply/subtract stages, magnitude stage, range check,
// 24 restoring divider stages, final saturate/clamp stage.
// Throughput: one transaction per cycle while the receiver does not stall; the
// divider retires one quotient bit per stage, so every stage can take a new item each cycle.
// Reset (synchronous, active low): table returns to its default points, all
// pipeline and queue contents are dropped.
// Receiver stall: the back pipeline freezes as a whole, the 4-entry queue
// soaks up the front, then s_axis_tready drops.
module calibration_table_interpolator #(
    parameter int POINTS = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cti_pkg::W_ADDR-1:0]      i_cfg_addr,
    input  logic [cti_pkg::W_VAL-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cti_pkg::W_TDATA_IN-1:0]  s_axis_tdata,   // [8:0] detector_volts
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cti_pkg::W_VAL-1:0]       m_axis_tdata,   // [23:0] mapped_value
    output logic [1:0]                      m_axis_tuser    // [0] was_clamped, [1] table_error
);
    import cti_pkg::*;

    // configuration registers
    logic [W_VOLT-1:0]        r_volt  [POINTS];
    logic signed [W_VAL-1:0]  r_value [POINTS];
    logic signed [W_VAL-1:0]  r_floor;

    logic                     push;
    logic                     full;
    t_job                     front_job;
    logic                     q_valid;
    logic                     pop;
    t_job                     q_job;
    logic signed [W_VAL-1:0]  out_value;
    logic                     out_clamped;
    logic                     out_error;

    // point i lives at REG_VOLT_A + i and REG_VALUE_A + i, the floor at REG_FLOOR; other indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POINTS; i++) begin
                r_volt[i]  <= RST_VOLT[i];
                r_value[i] <= RST_VALUE[i];
            end
            r_floor <= RST_FLOOR;
        end else if (i_cfg_we) begin
            for (int i = 0; i < POINTS; i++) begin
                if (i_cfg_addr == REG_VOLT_A + W_ADDR'(i)) begin
                    r_volt[i] <= i_cfg_wdata[W_VOLT-1:0];
                end
                if (i_cfg_addr == REG_VALUE_A + W_ADDR'(i)) begin
                    r_value[i] <= signed'(i_cfg_wdata);
                end
            end
            if (i_cfg_addr == REG_FLOOR) begin
                r_floor <= signed'(i_cfg_wdata);
            end
        end
    end

    // front: segment choice and operand setup
    cti_front #(
        .POINTS (POINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[W_VOLT-1:0]),
        .i_volt  (r_volt),
        .i_value (r_value),
        .o_push  (push),
        .o_job   (front_job),
        .i_full  (full)
    );

    cti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    // back: multiply, divide, saturate and floor
    cti_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_pop     (pop),
        .i_job     (q_job),
        .i_floor   (r_floor),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (out_value),
        .o_clamped (out_clamped),
        .o_error   (out_error)
    );

    assign m_axis_tdata = out_value;
    assign m_axis_tuser = {out_error, out_clamped};

endmodule

// ===== src/cti_checker.sv =====
module cti_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [cti_pkg::W_VAL-1:0]   i_out_data,
    input  logic [1:0]                  i_out_user
);

    // a held result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data) && $stable(i_out_user))
        else $error("output payload changed while stalled");

    // a table error result is never also a floor clamp
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_user[0] && i_out_user[1]))
        else $error("clamp and table error both set");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind calibration_table_interpolator cti_checker u_cti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (m_axis_tvalid),
    .i_out_ready (m_axis_tready),
    .i_out_data  (m_axis_tdata),
    .i_out_user  (m_axis_tuser)
);
